### src/mfs_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and state encoding of the multilevel feedback scheduler.
package mfs_pkg;

    // Sizing: process ids are 4 bits and the reported level is 2 bits wide
    localparam int MAX_PROCS  = 16;
    localparam int NUM_LEVELS = 4;
    localparam int LAST_LEVEL = NUM_LEVELS - 1;
    localparam int ID_W       = 4;
    localparam int LVL_W      = $clog2(NUM_LEVELS);
    localparam int POS_W      = $clog2(MAX_PROCS);
    localparam int CNT_W      = POS_W + 1;
    localparam int TIME_W     = 16;
    localparam int Q_W        = 3;
    localparam int TBL_W      = $clog2(MAX_PROCS);

    // Stream word layout
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    // Register map (word index of paddr)
    localparam int APB_ADDR_W = 4;
    localparam logic [1:0] REG_QUANTUM0 = 2'd0;
    localparam logic [1:0] REG_QUANTUM1 = 2'd1;
    localparam logic [1:0] REG_QUANTUM2 = 2'd2;

    // Reset quanta
    localparam logic [Q_W-1:0] QUANTUM0_RST = 3'd1;
    localparam logic [Q_W-1:0] QUANTUM1_RST = 3'd2;
    localparam logic [Q_W-1:0] QUANTUM2_RST = 3'd4;

    // Item kinds
    localparam logic FUNC_TICK    = 1'b0;
    localparam logic FUNC_ARRIVAL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_POP,
        ST_DEC,
        ST_LOAD,
        ST_OUT
    } mfs_state_t;

    // Command word from the sequencer to the FIFO bank
    typedef struct packed {
        logic             push;
        logic [LVL_W-1:0] push_lvl;
        logic [ID_W-1:0]  push_id;
        logic             pop;
        logic [LVL_W-1:0] pop_lvl;
    } mfs_fifo_cmd_t;

    // Status of all level FIFOs
    typedef struct packed {
        logic [NUM_LEVELS-1:0] nonempty;
        logic [NUM_LEVELS-1:0] full;
    } mfs_fifo_stat_t;

endpackage

### src/mfs_fifo_bank.sv
`timescale 1ns / 1ps
// Bank of per-level id FIFOs sharing one storage memory with a registered read port.
module mfs_fifo_bank (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  mfs_pkg::mfs_fifo_cmd_t         cmd,
    output mfs_pkg::mfs_fifo_stat_t        stat,
    output logic [mfs_pkg::ID_W-1:0]       pop_id
);

    localparam int MEM_DEPTH = mfs_pkg::NUM_LEVELS * mfs_pkg::MAX_PROCS;
    localparam int MEM_AW    = mfs_pkg::LVL_W + mfs_pkg::POS_W;

    logic [mfs_pkg::ID_W-1:0]  store_mem [MEM_DEPTH];
    logic [mfs_pkg::POS_W-1:0] heads_reg  [mfs_pkg::NUM_LEVELS];
    logic [mfs_pkg::POS_W-1:0] heads_next [mfs_pkg::NUM_LEVELS];
    logic [mfs_pkg::CNT_W-1:0] counts_reg [mfs_pkg::NUM_LEVELS];
    logic [mfs_pkg::CNT_W-1:0] counts_next[mfs_pkg::NUM_LEVELS];
    logic                      push_ok;
    logic [mfs_pkg::POS_W-1:0] tail_pos;
    logic [mfs_pkg::POS_W-1:0] head_pos;
    logic [MEM_AW-1:0]         waddr;
    logic [MEM_AW-1:0]         raddr;
    logic [mfs_pkg::ID_W-1:0]  pop_id_reg;

    // Flag levels that hold ids or have no room left
    always_comb begin
        for (int i = 0; i < mfs_pkg::NUM_LEVELS; i++) begin
            stat.nonempty[i] = (counts_reg[i] != '0);
            stat.full[i]     = counts_reg[i][mfs_pkg::CNT_W-1];
        end
    end

    // Select tail of the pushed level and head of the popped level
    always_comb begin
        tail_pos = '0;
        head_pos = '0;
        for (int i = 0; i < mfs_pkg::NUM_LEVELS; i++) begin
            if (cmd.push_lvl == mfs_pkg::LVL_W'(i)) begin
                tail_pos = heads_reg[i] + counts_reg[i][mfs_pkg::POS_W-1:0];
            end
            if (cmd.pop_lvl == mfs_pkg::LVL_W'(i)) begin
                head_pos = heads_reg[i];
            end
        end
    end

    // Drop a push into a full level
    assign push_ok = cmd.push && !stat.full[cmd.push_lvl];
    assign waddr   = {cmd.push_lvl, tail_pos};
    assign raddr   = {cmd.pop_lvl, head_pos};

    // Advance heads and counts; a level may see a push and a pop together
    always_comb begin
        for (int i = 0; i < mfs_pkg::NUM_LEVELS; i++) begin
            heads_next[i]  = heads_reg[i];
            counts_next[i] = counts_reg[i];
            if (cmd.pop && cmd.pop_lvl == mfs_pkg::LVL_W'(i)) begin
                heads_next[i]  = heads_reg[i] + 1'b1;
                counts_next[i] = counts_next[i] - 1'b1;
            end
            if (push_ok && cmd.push_lvl == mfs_pkg::LVL_W'(i)) begin
                counts_next[i] = counts_next[i] + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mfs_pkg::NUM_LEVELS; i++) begin
                heads_reg[i]  <= '0;
                counts_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < mfs_pkg::NUM_LEVELS; i++) begin
                heads_reg[i]  <= heads_next[i];
                counts_reg[i] <= counts_next[i];
            end
        end
    end

    // Storage memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (push_ok) begin
            store_mem[waddr] <= cmd.push_id;
        end
        if (cmd.pop) begin
            pop_id_reg <= store_mem[raddr];
        end
    end

    assign pop_id = pop_id_reg;

endmodule

### src/multilevel_feedback_scheduler.sv
`timescale 1ns / 1ps
// Top level of the four-level feedback scheduler: sequencer, run-time table and ports.
//
// Takes one item at a time. An arrival word goes through table write, output load and
// output before its result word is offered; a tick word goes through evaluate, a pop
// step if a new runner is popped, decrement, output load and output, as the level FIFOs
// share one memory with a registered read port and the run-time table is decremented apart.
// s_axis_tready stays low from acceptance until the result word is taken. Input word:
// tuser is the kind (0 tick, 1 arrival); tdata carries proc_id and burst. Output word
// reports the running process after each item and whether an arrival was dropped
// because the level-0 queue was full. Quanta of levels 0 to 2 are set through the
// register port at byte addresses 0, 4 and 8; write them only while no word is in
// flight. No clearing pass is needed after reset.
module multilevel_feedback_scheduler (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // APB register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mfs_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    // Input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [mfs_pkg::IN_DATA_W-1:0]        s_axis_tdata,  // proc_id[3:0], burst[19:4]
    input  logic [0:0]                           s_axis_tuser,  // func[0]
    // Result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // running_valid[0], running_id[4:1], active_level[6:5], time_remaining[22:7],
    // arrival_dropped[23]
    output logic [mfs_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

    mfs_pkg::mfs_state_t        state_reg, state_next;
    mfs_pkg::mfs_fifo_cmd_t     fifo_cmd;
    mfs_pkg::mfs_fifo_stat_t    fifo_stat;
    logic [mfs_pkg::ID_W-1:0]   pop_id;

    logic [mfs_pkg::Q_W-1:0]    quantum0_reg, quantum1_reg, quantum2_reg;
    logic                       cfg_write;

    logic                       runner_valid_reg, runner_valid_next;
    logic [mfs_pkg::ID_W-1:0]   runner_id_reg, runner_id_next;
    logic [mfs_pkg::LVL_W-1:0]  runner_level_reg, runner_level_next;
    logic [mfs_pkg::Q_W-1:0]    slice_left_reg, slice_left_next;
    logic                       fcfs_mode_reg, fcfs_mode_next;
    logic [mfs_pkg::LVL_W-1:0]  sel_level_reg, sel_level_next;
    logic                       dropped_reg, dropped_next;
    logic [mfs_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic [mfs_pkg::TIME_W-1:0] time_left_mem [mfs_pkg::MAX_PROCS];
    logic                       tbl_we;
    logic [mfs_pkg::TBL_W-1:0]  tbl_waddr;
    logic [mfs_pkg::TIME_W-1:0] tbl_wdata;
    logic [mfs_pkg::TIME_W-1:0] time_cur;
    logic [mfs_pkg::TIME_W-1:0] time_dec;

    logic                       in_func;
    logic [mfs_pkg::ID_W-1:0]   in_id;
    logic [mfs_pkg::TIME_W-1:0] in_burst;

    logic                       alive;
    logic                       need_sel;
    logic                       none_ready;
    logic [mfs_pkg::LVL_W-1:0]  first_lvl;
    logic [mfs_pkg::LVL_W-1:0]  down_lvl;
    logic                       stay_demoted;
    logic [mfs_pkg::LVL_W-1:0]  enter_lvl;
    logic                       enter_en;

    // Round-robin slice granted on entry to a level
    function automatic logic [mfs_pkg::Q_W-1:0] level_quantum(
        input logic [mfs_pkg::LVL_W-1:0] lvl,
        input logic [mfs_pkg::Q_W-1:0]   q0,
        input logic [mfs_pkg::Q_W-1:0]   q1,
        input logic [mfs_pkg::Q_W-1:0]   q2
    );
        logic [mfs_pkg::Q_W-1:0] q;
        priority if (lvl == mfs_pkg::LVL_W'(0)) begin
            q = q0;
        end else if (lvl == mfs_pkg::LVL_W'(1)) begin
            q = q1;
        end else begin
            q = q2;
        end
        return q;
    endfunction

    // Unpack the input word
    assign in_func  = s_axis_tuser[0];
    assign in_id    = s_axis_tdata[mfs_pkg::ID_W-1:0];
    assign in_burst = s_axis_tdata[mfs_pkg::ID_W +: mfs_pkg::TIME_W];

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quantum0_reg <= mfs_pkg::QUANTUM0_RST;
            quantum1_reg <= mfs_pkg::QUANTUM1_RST;
            quantum2_reg <= mfs_pkg::QUANTUM2_RST;
        end else if (cfg_write) begin
            if (paddr[3:2] == mfs_pkg::REG_QUANTUM0) quantum0_reg <= pwdata[mfs_pkg::Q_W-1:0];
            if (paddr[3:2] == mfs_pkg::REG_QUANTUM1) quantum1_reg <= pwdata[mfs_pkg::Q_W-1:0];
            if (paddr[3:2] == mfs_pkg::REG_QUANTUM2) quantum2_reg <= pwdata[mfs_pkg::Q_W-1:0];
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            mfs_pkg::REG_QUANTUM0: prdata = {29'd0, quantum0_reg};
            mfs_pkg::REG_QUANTUM1: prdata = {29'd0, quantum1_reg};
            mfs_pkg::REG_QUANTUM2: prdata = {29'd0, quantum2_reg};
            default:               prdata = 32'd0;
        endcase
    end

    // Level FIFOs
    mfs_fifo_bank u_fifo_bank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (fifo_cmd),
        .stat    (fifo_stat),
        .pop_id  (pop_id)
    );

    // Run-time table, read at the runner's id
    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            time_left_mem[tbl_waddr] <= tbl_wdata;
        end
    end

    assign time_cur = time_left_mem[runner_id_reg[mfs_pkg::TBL_W-1:0]];
    assign time_dec = (time_cur == '0) ? '0 : time_cur - 1'b1;

    // Pick the highest-priority non-empty level
    always_comb begin
        none_ready = 1'b1;
        first_lvl  = '0;
        for (int i = mfs_pkg::NUM_LEVELS - 1; i >= 0; i--) begin
            if (fifo_stat.nonempty[i]) begin
                none_ready = 1'b0;
                first_lvl  = mfs_pkg::LVL_W'(i);
            end
        end
    end

    // Re-selection decision
    assign alive    = runner_valid_reg && (time_cur != '0);
    assign need_sel = !alive || (!fcfs_mode_reg && slice_left_reg == '0);
    assign down_lvl = (runner_level_reg == mfs_pkg::LVL_W'(mfs_pkg::LAST_LEVEL))
                      ? runner_level_reg : runner_level_reg + 1'b1;
    assign stay_demoted = alive && (none_ready ||
                          ({1'b0, runner_level_reg} + 1'b1 < {1'b0, first_lvl}));

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= mfs_pkg::ST_IDLE;
            runner_valid_reg <= 1'b0;
            runner_id_reg    <= '0;
            runner_level_reg <= '0;
            slice_left_reg   <= '0;
            fcfs_mode_reg    <= 1'b0;
        end else begin
            state_reg        <= state_next;
            runner_valid_reg <= runner_valid_next;
            runner_id_reg    <= runner_id_next;
            runner_level_reg <= runner_level_next;
            slice_left_reg   <= slice_left_next;
            fcfs_mode_reg    <= fcfs_mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        sel_level_reg <= sel_level_next;
        dropped_reg   <= dropped_next;
        out_data_reg  <= out_data_next;
    end

    always_comb begin
        state_next        = state_reg;
        runner_valid_next = runner_valid_reg;
        runner_id_next    = runner_id_reg;
        runner_level_next = runner_level_reg;
        slice_left_next   = slice_left_reg;
        fcfs_mode_next    = fcfs_mode_reg;
        sel_level_next    = sel_level_reg;
        dropped_next      = dropped_reg;
        out_data_next     = out_data_reg;
        fifo_cmd          = '0;
        tbl_we            = 1'b0;
        tbl_waddr         = in_id[mfs_pkg::TBL_W-1:0];
        tbl_wdata         = in_burst;
        enter_en          = 1'b0;
        enter_lvl         = down_lvl;
        s_axis_tready     = 1'b0;
        m_axis_tvalid     = 1'b0;

        unique case (state_reg)
            mfs_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    dropped_next = 1'b0;
                    if (in_func == mfs_pkg::FUNC_ARRIVAL) begin
                        // Append to level 0 and record the burst, or drop
                        if (fifo_stat.full[0]) begin
                            dropped_next = 1'b1;
                        end else begin
                            fifo_cmd.push     = 1'b1;
                            fifo_cmd.push_lvl = '0;
                            fifo_cmd.push_id  = in_id;
                            tbl_we            = 1'b1;
                        end
                        state_next = mfs_pkg::ST_LOAD;
                    end else begin
                        state_next = mfs_pkg::ST_EVAL;
                    end
                end
            end
            mfs_pkg::ST_EVAL: begin
                state_next = mfs_pkg::ST_DEC;
                if (need_sel) begin
                    priority if (stay_demoted) begin
                        // Demote the runner in place
                        enter_en  = 1'b1;
                        enter_lvl = down_lvl;
                    end else if (!none_ready) begin
                        // Push the live runner down, pop the chosen head
                        fifo_cmd.push     = alive;
                        fifo_cmd.push_lvl = down_lvl;
                        fifo_cmd.push_id  = runner_id_reg;
                        fifo_cmd.pop      = 1'b1;
                        fifo_cmd.pop_lvl  = first_lvl;
                        sel_level_next    = first_lvl;
                        state_next        = mfs_pkg::ST_POP;
                    end else begin
                        runner_valid_next = 1'b0;
                        runner_id_next    = '0;
                    end
                end
            end
            mfs_pkg::ST_POP: begin
                runner_id_next    = pop_id;
                runner_valid_next = 1'b1;
                enter_en          = 1'b1;
                enter_lvl         = sel_level_reg;
                state_next        = mfs_pkg::ST_DEC;
            end
            mfs_pkg::ST_DEC: begin
                // Charge one time unit and one slice unit to the runner
                if (runner_valid_reg) begin
                    tbl_we    = 1'b1;
                    tbl_waddr = runner_id_reg[mfs_pkg::TBL_W-1:0];
                    tbl_wdata = time_dec;
                    if (!fcfs_mode_reg && slice_left_reg != '0) begin
                        slice_left_next = slice_left_reg - 1'b1;
                    end
                end
                state_next = mfs_pkg::ST_LOAD;
            end
            mfs_pkg::ST_LOAD: begin
                if (runner_valid_reg) begin
                    out_data_next = {dropped_reg, time_cur, runner_level_reg,
                                     runner_id_reg, 1'b1};
                end else begin
                    out_data_next = {dropped_reg, {(mfs_pkg::OUT_DATA_W-1){1'b0}}};
                end
                state_next = mfs_pkg::ST_OUT;
            end
            mfs_pkg::ST_OUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    state_next = mfs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mfs_pkg::ST_IDLE;
            end
        endcase

        // Enter a level: last level runs to completion, others get a slice
        if (enter_en) begin
            runner_level_next = enter_lvl;
            if (enter_lvl == mfs_pkg::LVL_W'(mfs_pkg::LAST_LEVEL)) begin
                fcfs_mode_next  = 1'b1;
                slice_left_next = '0;
            end else begin
                fcfs_mode_next  = 1'b0;
                slice_left_next = level_quantum(enter_lvl, quantum0_reg,
                                                quantum1_reg, quantum2_reg);
            end
        end
    end

    assign m_axis_tdata = out_data_reg;

    // Checks
    a_fcfs_last_level: assert property (@(posedge aclk) disable iff (!aresetn)
        fcfs_mode_reg == (runner_level_reg == mfs_pkg::LVL_W'(mfs_pkg::LAST_LEVEL)))
        else $error("fcfs mode out of step with runner level");

    a_fcfs_no_slice: assert property (@(posedge aclk) disable iff (!aresetn)
        fcfs_mode_reg |-> slice_left_reg == '0)
        else $error("slice count left in fcfs mode");

    a_idle_word_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[22:1] == '0)
        else $error("runner fields not cleared with no runner");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word taken before result delivered");

endmodule
